// ===== rtl/core/uri_request_target_checker_core_assert.svh =====
// Assertion macros used by the request-target checker core.
`ifndef URI_REQUEST_TARGET_CHECKER_CORE_ASSERT_SVH
`define URI_REQUEST_TARGET_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define URTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uri_rtc assertion failed");

// Next-cycle implication, disabled during reset.
`define URTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uri_rtc assertion failed");

`endif

// ===== rtl/core/uri_rtc_pkg.sv =====
// Shared types, codes and helpers for the request-target checker.
`default_nettype none

package uri_rtc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PART_W = 4;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [PART_W-1:0] {
      PART_START    = 4'd0,
      PART_SCHEME   = 4'd1,
      PART_COLON    = 4'd2,
      PART_SLASH    = 4'd3,
      PART_AUTH     = 4'd4,
      PART_AFTER_AT = 4'd5,
      PART_PATH     = 4'd6,
      PART_QUERY    = 4'd7,
      PART_FRAG     = 4'd8,
      PART_ERROR    = 4'd9
   } part_type;

   typedef struct packed {
      part_type part;
      logic     terminator;
      logic     bad_char;
   } step_result_type;

   // Codes above the error code map to error.
   function automatic part_type clamp_part(input logic [PART_W-1:0] v);
      part_type p;
      if (v > PART_ERROR) begin
         p = PART_ERROR;
      end else begin
         p = part_type'(v);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uri_request_target_checker_core.sv =====
// Top level of the byte-serial HTTP request-target checker.
// Takes one request-target byte per beat and returns one result beat per byte: the byte,
// the URI part after it, a terminator flag on tlast (space ending the target) and a
// bad-character flag on tuser. Throughput is one byte per clock while rsp_tready does not
// stall the output; each byte passes the input register, then the result register.
// A byte can be taken while a result waits on rsp_tready, since the input register
// holds it. csr_data loads the start part and also resets the current part to it;
// write it only when no beat is in flight. Codes above 9 behave as the error part.
`default_nettype none

`include "uri_request_target_checker_core_assert.svh"

module uri_request_target_checker_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] in_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [7:0] byte_out, [11:8] part, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,  // terminator
   output logic        rsp_tuser,  // bad_char
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   import uri_rtc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff;
   step_result_type out_res_ff;
   part_type        parse_state_ff, parse_state_in;
   logic [3:0]      start_state_ff, start_state_in;
   step_result_type step_res;
   logic            out_load;
   logic            in_load;

   uri_rtc_step u_step (
      .cur_part    (parse_state_ff),
      .start_state (start_state_ff),
      .in_byte     (in_byte_ff),
      .result      (step_res)
   );

   assign csr_ready  = 1'b1;
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in    = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_ff);
      out_valid_in   = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      start_state_in = start_state_ff;
      parse_state_in = parse_state_ff;
      if (out_load) parse_state_in = step_res.part;
      if (csr_valid) begin
         start_state_in = csr_data;
         parse_state_in = clamp_part(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         start_state_ff <= 4'd0;
         parse_state_ff <= PART_START;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         start_state_ff <= start_state_in;
         parse_state_ff <= parse_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) in_byte_ff <= req_tdata;
      if (out_load) begin
         out_byte_ff <= in_byte_ff;
         out_res_ff  <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff.part, out_byte_ff};
   assign rsp_tlast  = out_res_ff.terminator;
   assign rsp_tuser  = out_res_ff.bad_char;

   `URTC_ASSERT_IMP(a_state_in_range, clock, reset, 1'b1, parse_state_ff <= PART_ERROR)
   `URTC_ASSERT_IMP(a_term_not_bad, clock, reset, rsp_tvalid && rsp_tlast, !rsp_tuser)
   `URTC_ASSERT_IMP(a_bad_is_error, clock, reset, rsp_tvalid && rsp_tuser,
                    rsp_tdata[11:8] == PART_ERROR)
   `URTC_ASSERT_NXT(a_space_restarts, clock, reset, out_load && in_byte_ff == CHAR_SPACE,
                    parse_state_ff == clamp_part(start_state_ff))
   `URTC_ASSERT_NXT(a_error_sticks, clock, reset,
                    out_load && !csr_valid && parse_state_ff == PART_ERROR &&
                    in_byte_ff != CHAR_SPACE, parse_state_ff == PART_ERROR)

endmodule

`default_nettype wire

// ===== rtl/core/uri_rtc_step.sv =====
// Per-byte character classification and part transition.
`default_nettype none

module uri_rtc_step (
   input  uri_rtc_pkg::part_type        cur_part,
   input  logic [3:0]                   start_state,
   input  logic [7:0]                   in_byte,
   output uri_rtc_pkg::step_result_type result
);
   import uri_rtc_pkg::*;

   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_QUEST   = 8'h3F;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
   endfunction

   function automatic logic is_sub_delim(input logic [7:0] c);
      // ! $ & ' ( ) * + , ; =
      return (c inside {8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D});
   endfunction

   function automatic logic is_auth_char(input logic [7:0] c);
      return is_unreserved(c) || is_sub_delim(c) || c == CHAR_PERCENT || c == CHAR_COLON;
   endfunction

   function automatic logic is_path_char(input logic [7:0] c);
      return is_auth_char(c) || c == CHAR_AT || c == CHAR_SLASH;
   endfunction

   part_type nxt;

   always_comb begin
      nxt = PART_ERROR;
      case (cur_part)
         PART_START: begin
            if (in_byte == CHAR_SLASH || in_byte == CHAR_STAR) nxt = PART_PATH;
            else if (is_alpha(in_byte)) nxt = PART_SCHEME;
         end
         PART_SCHEME: begin
            if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CHAR_PLUS ||
                in_byte == CHAR_MINUS || in_byte == CHAR_DOT) nxt = PART_SCHEME;
            else if (in_byte == CHAR_COLON) nxt = PART_COLON;
         end
         PART_COLON: begin
            if (in_byte == CHAR_SLASH) nxt = PART_SLASH;
         end
         PART_SLASH: begin
            if (in_byte == CHAR_SLASH) nxt = PART_AUTH;
         end
         PART_AUTH, PART_AFTER_AT: begin
            if (is_auth_char(in_byte)) nxt = cur_part;
            // only one '@' per authority
            else if (in_byte == CHAR_AT)
               nxt = (cur_part == PART_AUTH) ? PART_AFTER_AT : PART_ERROR;
            else if (in_byte == CHAR_SLASH) nxt = PART_PATH;
            else if (in_byte == CHAR_QUEST) nxt = PART_QUERY;
            else if (in_byte == CHAR_HASH) nxt = PART_FRAG;
         end
         PART_PATH: begin
            if (is_path_char(in_byte)) nxt = PART_PATH;
            else if (in_byte == CHAR_QUEST) nxt = PART_QUERY;
            else if (in_byte == CHAR_HASH) nxt = PART_FRAG;
         end
         PART_QUERY: begin
            if (is_path_char(in_byte) || in_byte == CHAR_QUEST) nxt = PART_QUERY;
            else if (in_byte == CHAR_HASH) nxt = PART_FRAG;
         end
         PART_FRAG: begin
            if (is_path_char(in_byte) || in_byte == CHAR_QUEST) nxt = PART_FRAG;
         end
         default: nxt = PART_ERROR;
      endcase
   end

   always_comb begin
      result.terminator = 1'b0;
      result.bad_char   = 1'b0;
      if (in_byte == CHAR_SPACE) begin
         result.terminator = 1'b1;
         result.part       = clamp_part(start_state);
      end else if (cur_part == PART_ERROR) begin
         result.part = PART_ERROR;
      end else begin
         result.part     = nxt;
         result.bad_char = (nxt == PART_ERROR);
      end
   end

endmodule

`default_nettype wire
